### src/dpw_pkg.sv
// shared types, constants and register map for the depth pixel to world point block
package dpw_pkg;

    // frame limits, pixels at or beyond these are dropped
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;

    // divider: quotient bits kept before saturation, numerator width, total latency
    localparam int DIV_BITS = 33;
    localparam int NUM_W    = 32 + 16 + 1;
    localparam int DIV_LAT  = DIV_BITS + 3;

    // configuration port
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_PRINCIPAL_POINT = 3'd0;
    localparam logic [2:0] REG_FOCAL_LENGTHS   = 3'd1;
    localparam logic [2:0] REG_DEPTH_SCALE     = 3'd2;
    localparam logic [2:0] REG_ROTATION_QUAT   = 3'd3;
    localparam logic [2:0] REG_TRANSLATION_X   = 3'd4;
    localparam logic [2:0] REG_TRANSLATION_Y   = 3'd5;
    localparam logic [2:0] REG_TRANSLATION_Z   = 3'd6;

    localparam logic [31:0] RST_PRINCIPAL_POINT = 32'h1458_0FD8;
    localparam logic [31:0] RST_FOCAL_LENGTHS   = 32'h2060_2070;
    localparam logic [15:0] RST_DEPTH_SCALE     = 16'd1000;
    localparam logic [63:0] RST_ROTATION_QUAT   = 64'h4000_0000_0000_0000;
    localparam logic [31:0] RST_TRANSLATION     = 32'h0000_0000;

    // rotation matrix in q.28
    localparam logic signed [35:0] Q28_ONE = 36'sd268435456;
    localparam logic signed [35:0] R_LIMIT = 36'sd536870912;

    typedef struct packed {
        logic [9:0]  column;
        logic [9:0]  row;
        logic [15:0] raw_depth;
        logic [7:0]  blue_in;
        logic [7:0]  green_in;
        logic [7:0]  red_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        cx;
        logic [15:0]        cy;
        logic [15:0]        fx;
        logic [15:0]        fy;
        logic [15:0]        scale;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } t_cfg;

    // one classified pixel waiting for the back end
    typedef struct packed {
        logic        sign_x;
        logic [31:0] mag_x;
        logic        sign_y;
        logic [31:0] mag_y;
        logic [15:0] depth;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

### src/dpw_div.sv
// pipelined rounding divider, one quotient bit per stage, saturating to signed 32 bits
module dpw_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_sign,
    input  logic [31:0]        i_mag,
    input  logic [31:0]        i_den,
    output logic signed [31:0] o_p
);
    localparam int NB = dpw_pkg::DIV_BITS;
    localparam int NW = dpw_pkg::NUM_W;

    logic [NW-1:0]      r_num_pre;
    logic               r_sign_pre;
    logic [31:0]        r_rem [0:NB];
    logic [NB-1:0]      r_num [0:NB];
    logic [NB-1:0]      r_q   [0:NB];
    logic               r_ovf [0:NB];
    logic               r_sgn [0:NB];
    logic [32:0]        trial [1:NB];
    logic               ge    [1:NB];
    logic [NB-1:0]      q_fin;
    logic               pos_ovf;
    logic               neg_ovf;
    logic signed [31:0] n_p;
    logic signed [31:0] r_p;

    always_comb begin
        for (int k = 1; k <= NB; k++) begin
            trial[k] = {r_rem[k-1], r_num[k-1][NB-1]};
            ge[k]    = trial[k] >= {1'b0, i_den};
        end
    end

    // saturate the magnitude quotient with its sign
    always_comb begin
        q_fin   = r_q[NB];
        pos_ovf = r_ovf[NB] | (|q_fin[NB-1:31]);
        neg_ovf = r_ovf[NB] | (|q_fin[NB-1:32]) | (q_fin[31] & (|q_fin[30:0]));
        if (r_sgn[NB]) begin
            n_p = neg_ovf ? 32'sh8000_0000 : -$signed(q_fin[31:0]);
        end else begin
            n_p = pos_ovf ? 32'sh7FFF_FFFF : $signed(q_fin[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // mag * 2^16 plus half the divisor gives round half away from zero
            r_num_pre  <= NW'({i_mag, 16'h0000}) + NW'(i_den[31:1]);
            r_sign_pre <= i_sign;
            r_rem[0]   <= 32'(r_num_pre[NW-1:NB]);
            r_num[0]   <= r_num_pre[NB-1:0];
            r_ovf[0]   <= 32'(r_num_pre[NW-1:NB]) >= i_den;
            r_sgn[0]   <= r_sign_pre;
            r_q[0]     <= '0;
            for (int k = 1; k <= NB; k++) begin
                r_rem[k] <= ge[k] ? 32'(trial[k] - {1'b0, i_den}) : trial[k][31:0];
                r_num[k] <= r_num[k-1] << 1;
                r_q[k]   <= {r_q[k-1][NB-2:0], ge[k]};
                r_ovf[k] <= r_ovf[k-1];
                r_sgn[k] <= r_sgn[k-1];
            end
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

### src/dpw_fifo.sv
// small register queue between the front classifier and the back datapath
module dpw_fifo #(
    parameter int DEPTH = dpw_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dpw_pkg::t_work   i_push_data,
    input  logic             i_pop,
    output dpw_pkg::t_work   o_pop_data,
    output dpw_pkg::t_qstat  o_stat
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dpw_pkg::t_work r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_pop_data   = r_mem[r_rd];
    assign o_stat.full  = r_cnt == CNT_W'(DEPTH);
    assign o_stat.empty = r_cnt == '0;

endmodule

### src/dpw_front.sv
// front end: takes pixels, drops empty or out-of-frame ones, forms the x and y numerators
module dpw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dpw_pkg::t_cfg       i_cfg,
    input  logic                i_in_valid,
    input  dpw_pkg::t_in_item   i_in_data,
    output logic                o_in_stall,
    output logic                o_work_valid,
    output dpw_pkg::t_work      o_work,
    input  logic                i_q_full
);
    logic signed [16:0] diff_x;
    logic signed [16:0] diff_y;
    logic [15:0]        abs_x;
    logic [15:0]        abs_y;
    logic               keep;
    logic               advance;
    dpw_pkg::t_work     n_work;
    dpw_pkg::t_work     r_work;
    logic               r_valid;

    always_comb begin
        // 16u - cx and 16v - cy, both in 1/16 pixel
        diff_x = $signed({3'b000, i_in_data.column, 4'h0}) - $signed({1'b0, i_cfg.cx});
        diff_y = $signed({3'b000, i_in_data.row, 4'h0}) - $signed({1'b0, i_cfg.cy});
        abs_x  = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
        abs_y  = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];
        keep   = (i_in_data.raw_depth != '0)
               && (13'(i_in_data.column) < 13'(dpw_pkg::MAX_COLUMNS))
               && (13'(i_in_data.row) < 13'(dpw_pkg::MAX_ROWS));

        n_work.sign_x = diff_x[16];
        n_work.mag_x  = 32'(abs_x) * 32'(i_in_data.raw_depth);
        n_work.sign_y = diff_y[16];
        n_work.mag_y  = 32'(abs_y) * 32'(i_in_data.raw_depth);
        n_work.depth  = i_in_data.raw_depth;
        n_work.red    = i_in_data.red_in;
        n_work.green  = i_in_data.green_in;
        n_work.blue   = i_in_data.blue_in;
    end

    assign advance      = !r_valid || !i_q_full;
    assign o_in_stall   = !advance;
    assign o_work_valid = r_valid;
    assign o_work       = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_in_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_work <= n_work;
        end
    end

endmodule

### src/dpw_back.sv
// back end: divisions, rotation, translation, saturation and the output register
module dpw_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dpw_pkg::t_cfg       i_cfg,
    input  logic                i_work_valid,
    input  dpw_pkg::t_work      i_work,
    output logic                o_pop,
    output logic                o_out_valid,
    output dpw_pkg::t_out_item  o_out_data,
    input  logic                i_out_stall
);
    localparam int LAT = dpw_pkg::DIV_LAT;
    localparam logic signed [65:0] ACC_HALF = 66'sd134217728;

    logic [15:0]        scale_nz;
    logic [15:0]        fx_nz;
    logic [15:0]        fy_nz;
    logic [31:0]        r_den_x;
    logic [31:0]        r_den_y;
    logic [31:0]        r_den_z;
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [35:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [30:0] n_rot [0:2][0:2];
    logic signed [30:0] r_rot [0:2][0:2];
    logic               en;
    logic               r_vld [0:LAT-1];
    logic [23:0]        r_rgb [0:LAT-1];
    logic signed [31:0] p     [0:2];
    logic signed [62:0] r_prod [0:2][0:2];
    logic               r_vld_p;
    logic [23:0]        r_rgb_p;
    logic signed [65:0] r_acc [0:2];
    logic               r_vld_s;
    logic [23:0]        r_rgb_s;
    logic signed [31:0] trans   [0:2];
    logic signed [37:0] shifted [0:2];
    logic signed [38:0] moved   [0:2];
    logic signed [31:0] n_world [0:2];
    logic               r_out_valid;
    dpw_pkg::t_out_item r_out_data;

    function automatic logic signed [30:0] sat_r(input logic signed [35:0] v);
        logic signed [35:0] c;
        c = v;
        if (c > dpw_pkg::R_LIMIT) begin
            c = dpw_pkg::R_LIMIT;
        end else if (c < -dpw_pkg::R_LIMIT) begin
            c = -dpw_pkg::R_LIMIT;
        end
        return 31'(c);
    endfunction

    // coefficients follow the registers, settled long before a pixel gets here
    assign scale_nz = (i_cfg.scale == '0) ? 16'd1 : i_cfg.scale;
    assign fx_nz    = (i_cfg.fx == '0) ? 16'd1 : i_cfg.fx;
    assign fy_nz    = (i_cfg.fy == '0) ? 16'd1 : i_cfg.fy;

    always_ff @(posedge i_clk) begin
        r_den_x <= 32'(scale_nz) * 32'(fx_nz);
        r_den_y <= 32'(scale_nz) * 32'(fy_nz);
        r_den_z <= 32'(scale_nz);
        r_xx    <= 32'($signed(i_cfg.qx)) * 32'($signed(i_cfg.qx));
        r_yy    <= 32'($signed(i_cfg.qy)) * 32'($signed(i_cfg.qy));
        r_zz    <= 32'($signed(i_cfg.qz)) * 32'($signed(i_cfg.qz));
        r_xy    <= 32'($signed(i_cfg.qx)) * 32'($signed(i_cfg.qy));
        r_xz    <= 32'($signed(i_cfg.qx)) * 32'($signed(i_cfg.qz));
        r_yz    <= 32'($signed(i_cfg.qy)) * 32'($signed(i_cfg.qz));
        r_wx    <= 32'($signed(i_cfg.qw)) * 32'($signed(i_cfg.qx));
        r_wy    <= 32'($signed(i_cfg.qw)) * 32'($signed(i_cfg.qy));
        r_wz    <= 32'($signed(i_cfg.qw)) * 32'($signed(i_cfg.qz));
        r_rot   <= n_rot;
    end

    always_comb begin
        xx = 36'(r_xx);
        yy = 36'(r_yy);
        zz = 36'(r_zz);
        xy = 36'(r_xy);
        xz = 36'(r_xz);
        yz = 36'(r_yz);
        wx = 36'(r_wx);
        wy = 36'(r_wy);
        wz = 36'(r_wz);
        n_rot[0][0] = sat_r(dpw_pkg::Q28_ONE - ((yy + zz) <<< 1));
        n_rot[0][1] = sat_r((xy - wz) <<< 1);
        n_rot[0][2] = sat_r((xz + wy) <<< 1);
        n_rot[1][0] = sat_r((xy + wz) <<< 1);
        n_rot[1][1] = sat_r(dpw_pkg::Q28_ONE - ((xx + zz) <<< 1));
        n_rot[1][2] = sat_r((yz - wx) <<< 1);
        n_rot[2][0] = sat_r((xz - wy) <<< 1);
        n_rot[2][1] = sat_r((yz + wx) <<< 1);
        n_rot[2][2] = sat_r(dpw_pkg::Q28_ONE - ((xx + yy) <<< 1));
    end

    // whole back end advances together unless a finished result is held
    assign en    = !r_out_valid || !i_out_stall;
    assign o_pop = en && i_work_valid;

    dpw_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sign (i_work.sign_x),
        .i_mag  (i_work.mag_x),
        .i_den  (r_den_x),
        .o_p    (p[0])
    );

    dpw_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sign (i_work.sign_y),
        .i_mag  (i_work.mag_y),
        .i_den  (r_den_y),
        .o_p    (p[1])
    );

    dpw_div u_div_z (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sign (1'b0),
        .i_mag  (32'(i_work.depth)),
        .i_den  (r_den_z),
        .o_p    (p[2])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_vld_p     <= 1'b0;
            r_vld_s     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_work_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_vld_p     <= r_vld[LAT-1];
            r_vld_s     <= r_vld_p;
            r_out_valid <= r_vld_s;
        end
    end

    assign trans[0] = i_cfg.tx;
    assign trans[1] = i_cfg.ty;
    assign trans[2] = i_cfg.tz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // floor of (acc + 2^27) / 2^28, then translate and clamp
            shifted[i] = 38'(r_acc[i] >>> 28);
            moved[i]   = 39'(shifted[i]) + 39'(trans[i]);
            if (moved[i] > 39'sd2147483647) begin
                n_world[i] = 32'sh7FFF_FFFF;
            end else if (moved[i] < -39'sd2147483648) begin
                n_world[i] = 32'sh8000_0000;
            end else begin
                n_world[i] = 32'(moved[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rgb[0] <= {i_work.red, i_work.green, i_work.blue};
            for (int k = 1; k < LAT; k++) begin
                r_rgb[k] <= r_rgb[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= 63'(r_rot[i][j]) * 63'(p[j]);
                end
                r_acc[i] <= 66'(r_prod[i][0]) + 66'(r_prod[i][1]) + 66'(r_prod[i][2])
                          + ACC_HALF;
            end
            r_rgb_p              <= r_rgb[LAT-1];
            r_rgb_s              <= r_rgb_p;
            r_out_data.world_x   <= n_world[0];
            r_out_data.world_y   <= n_world[1];
            r_out_data.world_z   <= n_world[2];
            r_out_data.red_out   <= r_rgb_s[23:16];
            r_out_data.green_out <= r_rgb_s[15:8];
            r_out_data.blue_out  <= r_rgb_s[7:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### src/depth_pixel_to_world_point.sv
// top level: register file, front classifier, queue and back datapath
//
// depth pixel to world point
// - input channel (i_in_valid, i_in_data, o_in_stall): one pixel per transfer with
//   column, row, raw depth and colour bytes; a transfer can happen every cycle
// - output channel (o_out_valid, o_out_data, i_out_stall): one world point per
//   pixel with nonzero depth inside the frame, in q16.16 metres plus the colour
// - pixels with zero depth or outside the frame make no output transfer
// - a pixel passes the front register, the queue, 36 divider stages, 2 rotation
//   stages and the output register; throughput is one pixel per cycle when the
//   output is not stalled, set by the bit-per-stage dividers
// - configuration is a 64-bit apb-style slave, register i at byte address 8*i;
//   write it only while no pixels are in flight; derived coefficients follow a
//   write through their own registers
// - reset clears the pipeline valid bits and queue, loads the default camera
//   (cx 325.5, cy 253.5, fx 518, fy 519, scale 1000) and an identity pose
// - when i_out_stall holds a result, the back datapath freezes; the front keeps
//   taking pixels into the queue until it fills, then raises o_in_stall
module depth_pixel_to_world_point #(
    parameter int FIFO_DEPTH = dpw_pkg::FIFO_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // pixel input
    input  logic                         i_in_valid,
    input  dpw_pkg::t_in_item            i_in_data,
    output logic                         o_in_stall,
    // world point output
    output logic                         o_out_valid,
    output dpw_pkg::t_out_item           o_out_data,
    input  logic                         i_out_stall,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dpw_pkg::ADDR_W-1:0]   paddr,
    input  logic [dpw_pkg::DATA_W-1:0]   pwdata,
    output logic [dpw_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    logic [31:0]       r_principal_point;
    logic [31:0]       r_focal_lengths;
    logic [15:0]       r_depth_scale;
    logic [63:0]       r_rotation_quat;
    logic [31:0]       r_translation_x;
    logic [31:0]       r_translation_y;
    logic [31:0]       r_translation_z;
    logic [2:0]        reg_index;
    logic              cfg_write;
    dpw_pkg::t_cfg     cfg;

    logic              front_valid;
    dpw_pkg::t_work    front_work;
    logic              work_push;
    logic              work_pop;
    dpw_pkg::t_work    queue_work;
    dpw_pkg::t_qstat   q_stat;

    // register file, the access phase completes a write
    assign pready    = 1'b1;
    assign reg_index = paddr[dpw_pkg::ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_principal_point <= dpw_pkg::RST_PRINCIPAL_POINT;
            r_focal_lengths   <= dpw_pkg::RST_FOCAL_LENGTHS;
            r_depth_scale     <= dpw_pkg::RST_DEPTH_SCALE;
            r_rotation_quat   <= dpw_pkg::RST_ROTATION_QUAT;
            r_translation_x   <= dpw_pkg::RST_TRANSLATION;
            r_translation_y   <= dpw_pkg::RST_TRANSLATION;
            r_translation_z   <= dpw_pkg::RST_TRANSLATION;
        end else if (cfg_write) begin
            unique case (reg_index)
                dpw_pkg::REG_PRINCIPAL_POINT: r_principal_point <= pwdata[31:0];
                dpw_pkg::REG_FOCAL_LENGTHS:   r_focal_lengths   <= pwdata[31:0];
                dpw_pkg::REG_DEPTH_SCALE:     r_depth_scale     <= pwdata[15:0];
                dpw_pkg::REG_ROTATION_QUAT:   r_rotation_quat   <= pwdata;
                dpw_pkg::REG_TRANSLATION_X:   r_translation_x   <= pwdata[31:0];
                dpw_pkg::REG_TRANSLATION_Y:   r_translation_y   <= pwdata[31:0];
                dpw_pkg::REG_TRANSLATION_Z:   r_translation_z   <= pwdata[31:0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            dpw_pkg::REG_PRINCIPAL_POINT: prdata = 64'(r_principal_point);
            dpw_pkg::REG_FOCAL_LENGTHS:   prdata = 64'(r_focal_lengths);
            dpw_pkg::REG_DEPTH_SCALE:     prdata = 64'(r_depth_scale);
            dpw_pkg::REG_ROTATION_QUAT:   prdata = r_rotation_quat;
            dpw_pkg::REG_TRANSLATION_X:   prdata = 64'(r_translation_x);
            dpw_pkg::REG_TRANSLATION_Y:   prdata = 64'(r_translation_y);
            dpw_pkg::REG_TRANSLATION_Z:   prdata = 64'(r_translation_z);
            default:                      prdata = '0;
        endcase
    end

    // unpacked view of the registers for both halves
    assign cfg.cx    = r_principal_point[31:16];
    assign cfg.cy    = r_principal_point[15:0];
    assign cfg.fx    = r_focal_lengths[31:16];
    assign cfg.fy    = r_focal_lengths[15:0];
    assign cfg.scale = r_depth_scale;
    assign cfg.qw    = r_rotation_quat[63:48];
    assign cfg.qx    = r_rotation_quat[47:32];
    assign cfg.qy    = r_rotation_quat[31:16];
    assign cfg.qz    = r_rotation_quat[15:0];
    assign cfg.tx    = r_translation_x;
    assign cfg.ty    = r_translation_y;
    assign cfg.tz    = r_translation_z;

    // front: accept, filter, form numerators
    dpw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .o_work_valid (front_valid),
        .o_work       (front_work),
        .i_q_full     (q_stat.full)
    );

    assign work_push = front_valid && !q_stat.full;

    // queue decouples front acceptance from back stalls
    dpw_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (work_push),
        .i_push_data (front_work),
        .i_pop       (work_pop),
        .o_pop_data  (queue_work),
        .o_stat      (q_stat)
    );

    // back: division, rotation, translation, output register
    dpw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_work_valid (!q_stat.empty),
        .i_work       (queue_work),
        .o_pop        (work_pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

    // a pixel with no depth never reaches the queue
    a_zero_depth_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.raw_depth == 16'h0000) |=> !front_valid)
        else $error("zero depth pixel passed the front end");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(work_push && q_stat.full))
        else $error("queue overflow");

    // a held result freezes the back end, so nothing leaves the queue
    a_stall_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !work_pop)
        else $error("queue popped while output stalled");

    // a full queue is never also empty
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue flags inconsistent");

endmodule
